FILE: src/pic_pkg.sv
// Shared types and constants for the priority interrupt controller.
// Holds the item structs, operation codes and the default parameter values.
// No dependencies.
package pic_pkg;

    localparam int PIC_NUM_LEVELS  = 5;
    localparam int PIC_COUNT_WIDTH = 24;

    localparam int LEVEL_W  = 3;
    localparam int MASK_W   = 4;
    localparam int PERIOD_W = 24;
    localparam int CAUSE_W  = 16;
    localparam int PC_W     = 32;
    localparam int VIDEO_W  = 16;
    localparam int PEND_W   = 5;

    localparam logic [1:0] OP_CHECK   = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam int TIMER_LEVEL = 1;
    localparam int VIDEO_LEVEL = 4;

    localparam logic [CAUSE_W-1:0]  CAUSE_BASE   = 16'hFE00;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd20000;

    typedef struct packed {
        logic [1:0]         operation;
        logic [LEVEL_W-1:0] level;
        logic               timer_underflow;
        logic [VIDEO_W-1:0] video_status;
        logic [VIDEO_W-1:0] video_enable;
        logic               int_disable;
        logic               exception_active;
        logic               nmi_active;
        logic [MASK_W-1:0]  mask_level;
        logic [PC_W-1:0]    current_pc;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic [LEVEL_W-1:0] accepted_level;
        logic [LEVEL_W-1:0] new_mask;
        logic [CAUSE_W-1:0] cause_code;
        logic [PC_W-1:0]    saved_pc;
        logic               frame_event;
        logic [PEND_W-1:0]  pending_out;
    } out_item_t;

endpackage

FILE: src/pic_core.sv
// Interrupt state and per-item evaluation: pending mask, frame tick counter,
// frame period register and the priority pick. Depends on pic_pkg.
module pic_core
    import pic_pkg::*;
#(
    parameter int NUM_LEVELS  = PIC_NUM_LEVELS,
    parameter int COUNT_WIDTH = PIC_COUNT_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  logic                fire,
    input  in_item_t            item,
    output out_item_t           result
);

    localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

    logic [NUM_LEVELS-1:0]  pending_reg, pending_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [PERIOD_W-1:0]    period_reg;

    logic [NUM_LEVELS-1:0]  lvl_hot, timer_hot, video_hot, top_hot;
    logic [NUM_LEVELS-1:0]  pend_mid;
    logic [COUNT_WIDTH-1:0] tick_inc, tick_upd;
    logic                   frame_wrap;
    logic                   video_hit;
    logic                   blocked;
    logic                   found;
    logic [LEVEL_W-1:0]     top_lvl;
    logic                   accept;

    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            lvl_hot[i]   = (item.level == LEVEL_W'(i));
            timer_hot[i] = (i == TIMER_LEVEL);
            video_hot[i] = (i == VIDEO_LEVEL);
        end
    end

    assign tick_inc  = tick_reg + COUNT_WIDTH'(1);
    assign video_hit = |(item.video_status & item.video_enable);
    assign blocked   = item.int_disable | item.exception_active | item.nmi_active;

    always_comb
    begin
        pend_mid   = pending_reg;
        tick_upd   = tick_reg;
        frame_wrap = 1'b0;
        unique case (item.operation)
            OP_REQUEST: pend_mid = pending_reg | lvl_hot;
            OP_CLEAR:   pend_mid = pending_reg & ~lvl_hot;
            OP_CHECK:
            begin
                if (item.timer_underflow)
                begin
                    pend_mid = pending_reg | timer_hot;
                end
                if (period_reg != '0)
                begin
                    // A lowered period that the count already passed wraps at once.
                    if (CMP_W'(tick_inc) >= CMP_W'(period_reg))
                    begin
                        tick_upd   = '0;
                        frame_wrap = 1'b1;
                        if (video_hit)
                        begin
                            pend_mid = pend_mid | video_hot;
                        end
                    end
                    else
                    begin
                        tick_upd = tick_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    // Highest set bit wins; acceptance then also needs a check item, no block flag and the mask compare.
    always_comb
    begin
        found   = 1'b0;
        top_lvl = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (pend_mid[i])
            begin
                found   = 1'b1;
                top_lvl = LEVEL_W'(i);
            end
        end
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            top_hot[i] = (top_lvl == LEVEL_W'(i));
        end
    end

    assign accept = (item.operation == OP_CHECK) && found && !blocked &&
                    ({1'b0, top_lvl} >= item.mask_level);

    assign pending_next = accept ? (pend_mid & ~top_hot) : pend_mid;
    assign tick_next    = tick_upd;

    always_comb
    begin
        result                = '0;
        result.frame_event    = frame_wrap;
        result.pending_out    = PEND_W'(pending_next);
        if (accept)
        begin
            result.accepted       = 1'b1;
            result.accepted_level = top_lvl;
            result.new_mask       = top_lvl + LEVEL_W'(1);
            result.cause_code     = CAUSE_BASE + CAUSE_W'({top_lvl, 4'b0000});
            result.saved_pc       = item.current_pc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            tick_reg    <= '0;
            period_reg  <= PERIOD_RESET;
        end
        else
        begin
            if (fire)
            begin
                pending_reg <= pending_next;
                tick_reg    <= tick_next;
            end
            if (cfg_write)
            begin
                period_reg <= cfg_wdata;
            end
        end
    end

    a_frame_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        (item.operation != OP_CHECK) |-> !result.frame_event)
        else $error("frame event on a non-check item");

    a_no_frame_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        (period_reg == '0) |-> (!result.frame_event && tick_next == tick_reg))
        else $error("frame counter moved while disabled");

    a_accept_not_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        result.accepted |-> (!blocked && item.operation == OP_CHECK))
        else $error("interrupt accepted while blocked");

endmodule

FILE: src/priority_interrupt_controller_core.sv
// Top level of the priority interrupt controller: input register, result
// register and handshake control around pic_core. Depends on pic_pkg, pic_core.
//
// Usage: items arrive on the in channel (in_valid, in_stall, in_item) and each
// item produces exactly one result on the out channel (out_valid, out_stall,
// out_item). An item is taken when valid is high and stall is low.
// The item waits in the input register while it is evaluated against the
// pending mask and frame counter, and the result is registered in the result
// register when the out channel can take it.
// Throughput is one item per cycle while the receiver does not stall; the
// pending mask and tick counter are updated when an item moves into the
// result register, so consecutive items see each other's effects in order.
// When the receiver stalls, the result holds; the input register still takes
// one more item, after which in_stall rises until the result drains.
// The frame period is written through cfg_write/cfg_wdata; the user must
// write it only while the block is idle; the block itself does not enforce this.
// Reset clears the pending mask and tick counter, empties both registers
// and loads the frame period with 20000.
module priority_interrupt_controller_core
    import pic_pkg::*;
#(
    parameter int NUM_LEVELS  = PIC_NUM_LEVELS,
    parameter int COUNT_WIDTH = PIC_COUNT_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_item
);

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    out_item_t core_result;
    logic      in_load;
    logic      advance;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_load  = in_valid && !in_stall;

    assign in_valid_next  = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && out_stall);

    pic_core #(
        .NUM_LEVELS  (NUM_LEVELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (in_item_reg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("item moved but no result was shown");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.accepted) |->
        (out_item_reg.accepted_level == '0 && out_item_reg.new_mask == '0 &&
         out_item_reg.cause_code == '0 && out_item_reg.saved_pc == '0))
        else $error("result fields set without an accepted interrupt");

    a_accept_fields_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.accepted) |->
        (out_item_reg.new_mask == out_item_reg.accepted_level + LEVEL_W'(1) &&
         out_item_reg.cause_code ==
         CAUSE_BASE + CAUSE_W'({out_item_reg.accepted_level, 4'b0000})))
        else $error("accepted interrupt fields disagree");

endmodule
